FILE: hdl/sle_pkg.sv
// Shared types, character codes and reset contents for the serial line editor.
// Depends on nothing; imported by the history store, the top level and the bench.
package sle_pkg;

   // Character codes recognised or produced by the editor.
   localparam logic [7:0] CH_XON     = 8'h11;
   localparam logic [7:0] CH_XOFF    = 8'h13;
   localparam logic [7:0] CH_DEL     = 8'h7F;
   localparam logic [7:0] CH_BS      = 8'h08;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_ESC     = 8'd27;
   localparam logic [7:0] CH_UP      = 8'd65;
   localparam logic [7:0] CH_DOWN    = 8'd66;
   localparam logic [7:0] CH_BRACKET = 8'd91;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_EQUALS  = 8'h3D;
   localparam logic [7:0] CH_GT      = 8'h3E;

   // Number of characters in the line that slot zero holds after reset.
   localparam int HELP_LEN = 4;

   // Sequencer states; each state other than idle emits one result per step.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ERASE,
      ST_RECALL,
      ST_ECHO,
      ST_CMD,
      ST_PROMPT
   } seq_state_type;

   // Progress through an escape sequence.
   typedef enum logic [1:0] {
      ESC_NONE,
      ESC_SEEN,
      ESC_BRACKET
   } esc_phase_type;

   // Characters of the line held in slot zero after reset.
   function automatic logic [7:0] help_char(input logic [1:0] pos);
      logic [7:0] ch;
      case (pos)
         2'd0:    ch = 8'h68;
         2'd1:    ch = 8'h65;
         2'd2:    ch = 8'h6C;
         2'd3:    ch = 8'h70;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

FILE: hdl/sle_history.sv
// History ring storage: one row per slot, one byte per line position.
// Depends on sle_pkg for the reset contents of slot zero.
module sle_history
   import sle_pkg::*;
#(
   parameter int SLOT_W = 3,
   parameter int IDX_W  = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [SLOT_W-1:0] wr_slot,
   input  logic [IDX_W-1:0]  wr_idx,
   input  logic [7:0]        wr_data,
   input  logic [SLOT_W-1:0] rd_slot,
   input  logic [IDX_W-1:0]  rd_idx,
   output logic [7:0]        rd_data
);

   localparam int ADDR_W = SLOT_W + IDX_W;
   localparam int DEPTH  = 1 << ADDR_W;

   logic [7:0]        history_ff [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   logic [7:0]        rd_q_ff;
   logic              hit_ff;
   logic [7:0]        init_q_ff;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_idx_ext;
   logic [7:0]        init_byte;

   assign wr_addr    = {wr_slot, wr_idx};
   assign rd_addr    = {rd_slot, rd_idx};
   assign rd_idx_ext = {{(8-IDX_W){1'b0}}, rd_idx};

   // Contents of an entry that has not been written since reset.
   always_comb begin
      if (rd_slot == '0 && rd_idx_ext < 8'(HELP_LEN)) begin
         init_byte = help_char(rd_idx_ext[1:0]);
      end else begin
         init_byte = 8'h00;
      end
   end

   // Storage array with a registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         history_ff[wr_addr] <= wr_data;
      end
      rd_q_ff   <= history_ff[rd_addr];
      init_q_ff <= init_byte;
   end

   // Written-entry flags, cleared at once by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         hit_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = hit_ff ? rd_q_ff : init_q_ff;

endmodule

FILE: hdl/serial_line_editor_with_history_top.sv
// Serial line editor with history: a request is one received byte; results are
// echo bytes and command-line bytes, emitted one per cycle by a sequencer while
// the output register can take them. A request is taken only in idle, so a new
// byte waits until every result of the last one has gone into the output register;
// the first result enters the output register after the state register has left
// idle. Synchronous reset; slot zero then holds "help".
module serial_line_editor_with_history_top
   import sle_pkg::*;
#(
   parameter int LINE_LEN      = 16,
   parameter int HISTORY_DEPTH = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_dest,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_cmd_end,
   output logic       rsp_last
);

   localparam int CUR_W  = $clog2(LINE_LEN + 1);
   localparam int IDX_W  = $clog2(LINE_LEN);
   localparam int SLOT_W = $clog2(HISTORY_DEPTH);
   localparam logic [CUR_W-1:0]  LINE_MAX  = CUR_W'(LINE_LEN);
   localparam logic [SLOT_W-1:0] SLOT_MAX  = SLOT_W'(HISTORY_DEPTH - 1);
   localparam logic [CUR_W-1:0]  RESET_LEN =
      CUR_W'((LINE_LEN < HELP_LEN) ? LINE_LEN : HELP_LEN);

   seq_state_type     state_ff, state_in;
   esc_phase_type     esc_ff, esc_in;
   logic [SLOT_W-1:0] cur_slot_ff, cur_slot_in;
   logic [CUR_W-1:0]  cursor_ff, cursor_in;
   logic [CUR_W-1:0]  slot_len_ff [HISTORY_DEPTH];
   logic [SLOT_W-1:0] seq_slot_ff, seq_slot_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [CUR_W-1:0]  cnt_ff, cnt_in;
   logic [1:0]        sub_ff, sub_in;
   logic [CUR_W-1:0]  len_ff, len_in;
   logic              do_recall_ff, do_recall_in;
   logic              do_cmd_ff, do_cmd_in;
   logic              do_prompt_ff, do_prompt_in;
   logic [7:0]        rx_ff, rx_in;
   logic              rsp_valid_ff;
   logic              rsp_dest_ff, rsp_dest_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;
   logic              rsp_end_ff, rsp_end_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              accept;
   logic              fire;
   logic              out_free;
   logic              is_cr_lf;
   logic              store;
   logic              complete;
   logic [CUR_W-1:0]  cursor_inc;
   logic [CUR_W-1:0]  cursor_new;
   logic [SLOT_W-1:0] recall_slot;
   logic [SLOT_W-1:0] next_slot;
   logic [SLOT_W-1:0] len_rd_slot;
   logic [CUR_W-1:0]  len_rd;
   logic              len_wr_en;
   logic [CUR_W-1:0]  len_wr_data;
   logic              wr_en;
   logic [7:0]        mem_data;
   logic              idx_final;

   // Handshake on both sides; the output register frees the sequencer from the consumer.
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fire      = out_free && (state_ff != ST_IDLE);

   // Decode helpers for an accepted byte.
   assign is_cr_lf    = (req_rx_byte == CH_CR) || (req_rx_byte == CH_LF);
   assign store       = !is_cr_lf && (cursor_ff < LINE_MAX);
   assign cursor_inc  = cursor_ff + CUR_W'(1);
   assign cursor_new  = store ? cursor_inc : cursor_ff;
   assign complete    = (cursor_new == LINE_MAX) || is_cr_lf;
   assign next_slot   = (cur_slot_ff == SLOT_MAX) ? '0 : cur_slot_ff + SLOT_W'(1);
   assign recall_slot = (req_rx_byte == CH_UP)
                        ? ((cur_slot_ff == '0) ? SLOT_MAX : cur_slot_ff - SLOT_W'(1))
                        : next_slot;
   assign len_rd_slot = (esc_ff == ESC_BRACKET) ? recall_slot : cur_slot_ff;
   assign len_rd      = slot_len_ff[len_rd_slot];
   assign idx_final   = (CUR_W'(idx_ff) + CUR_W'(1) == len_ff);

   sle_history #(
      .SLOT_W (SLOT_W),
      .IDX_W  (IDX_W)
   ) u_history (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_slot (cur_slot_ff),
      .wr_idx  (cursor_ff[IDX_W-1:0]),
      .wr_data (req_rx_byte),
      .rd_slot (seq_slot_in),
      .rd_idx  (idx_in),
      .rd_data (mem_data)
   );

   // Request decode in idle and result sequencing in the other states.
   always_comb begin
      state_in     = state_ff;
      esc_in       = esc_ff;
      cur_slot_in  = cur_slot_ff;
      cursor_in    = cursor_ff;
      seq_slot_in  = seq_slot_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      sub_in       = sub_ff;
      len_in       = len_ff;
      do_recall_in = do_recall_ff;
      do_cmd_in    = do_cmd_ff;
      do_prompt_in = do_prompt_ff;
      rx_in        = rx_ff;
      rsp_dest_in  = 1'b0;
      rsp_byte_in  = CH_BS;
      rsp_end_in   = 1'b0;
      rsp_last_in  = 1'b0;
      len_wr_en    = 1'b0;
      len_wr_data  = cursor_new;
      wr_en        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_rx_byte == CH_ESC) begin
                  esc_in = ESC_SEEN;
               end else if (esc_ff == ESC_SEEN) begin
                  esc_in = (req_rx_byte == CH_BRACKET) ? ESC_BRACKET : ESC_NONE;
               end else if (esc_ff == ESC_BRACKET) begin
                  esc_in = ESC_NONE;
                  // History recall: erase the shown line, then show the chosen slot.
                  if (req_rx_byte == CH_UP || req_rx_byte == CH_DOWN) begin
                     cnt_in       = cursor_ff;
                     sub_in       = 2'd0;
                     len_in       = len_rd;
                     do_recall_in = (len_rd != '0);
                     cur_slot_in  = recall_slot;
                     cursor_in    = len_rd;
                     seq_slot_in  = recall_slot;
                     idx_in       = '0;
                     if (cursor_ff != '0) begin
                        state_in = ST_ERASE;
                     end else if (len_rd != '0) begin
                        state_in = ST_RECALL;
                     end else begin
                        state_in = ST_IDLE;
                     end
                  end
               end else if (esc_ff != ESC_NONE) begin
                  esc_in = ESC_NONE;
               end else if (req_rx_byte == CH_BS || req_rx_byte == CH_DEL) begin
                  if (cursor_ff != '0) begin
                     cursor_in    = cursor_ff - CUR_W'(1);
                     cnt_in       = CUR_W'(1);
                     sub_in       = 2'd0;
                     do_recall_in = 1'b0;
                     state_in     = ST_ERASE;
                  end
               end else if (req_rx_byte == CH_XON || req_rx_byte == CH_XOFF) begin
                  state_in = ST_IDLE;
               end else begin
                  // Ordinary byte, line end or full line.
                  wr_en        = store;
                  rx_in        = req_rx_byte;
                  seq_slot_in  = cur_slot_ff;
                  idx_in       = '0;
                  sub_in       = 2'd0;
                  len_in       = cursor_new;
                  do_cmd_in    = complete && (cursor_new != '0);
                  do_prompt_in = complete;
                  if (complete) begin
                     len_wr_en   = 1'b1;
                     len_wr_data = cursor_new;
                     cursor_in   = '0;
                     if (cursor_new != '0) begin
                        cur_slot_in = next_slot;
                     end
                  end else begin
                     cursor_in = cursor_new;
                     if (store && len_rd < cursor_inc) begin
                        len_wr_en   = 1'b1;
                        len_wr_data = cursor_inc;
                     end
                  end
                  if (store) begin
                     state_in = ST_ECHO;
                  end else if (cursor_new != '0) begin
                     state_in = ST_CMD;
                  end else begin
                     state_in = ST_PROMPT;
                  end
               end
            end
         end

         ST_ERASE: begin
            rsp_byte_in = (sub_ff == 2'd1) ? CH_SPACE : CH_BS;
            rsp_last_in = (cnt_ff == CUR_W'(1)) && (sub_ff == 2'd2) && !do_recall_ff;
            if (fire) begin
               if (sub_ff == 2'd2) begin
                  sub_in = 2'd0;
                  cnt_in = cnt_ff - CUR_W'(1);
                  if (cnt_ff == CUR_W'(1)) begin
                     idx_in   = '0;
                     state_in = do_recall_ff ? ST_RECALL : ST_IDLE;
                  end
               end else begin
                  sub_in = sub_ff + 2'd1;
               end
            end
         end

         ST_RECALL: begin
            rsp_byte_in = mem_data;
            rsp_last_in = idx_final;
            if (fire) begin
               if (idx_final) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end

         ST_ECHO: begin
            rsp_byte_in = rx_ff;
            rsp_last_in = !do_prompt_ff;
            if (fire) begin
               idx_in = '0;
               sub_in = 2'd0;
               if (do_cmd_ff) begin
                  state_in = ST_CMD;
               end else if (do_prompt_ff) begin
                  state_in = ST_PROMPT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_CMD: begin
            rsp_dest_in = 1'b1;
            rsp_byte_in = mem_data;
            rsp_end_in  = idx_final;
            if (fire) begin
               if (idx_final) begin
                  sub_in   = 2'd0;
                  state_in = ST_PROMPT;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end

         ST_PROMPT: begin
            case (sub_ff)
               2'd0:    rsp_byte_in = CH_LF;
               2'd1:    rsp_byte_in = CH_EQUALS;
               default: rsp_byte_in = CH_GT;
            endcase
            rsp_last_in = (sub_ff == 2'd2);
            if (fire) begin
               if (sub_ff == 2'd2) begin
                  sub_in   = 2'd0;
                  state_in = ST_IDLE;
               end else begin
                  sub_in = sub_ff + 2'd1;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state of the editor and the sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         esc_ff      <= ESC_NONE;
         cur_slot_ff <= '0;
         cursor_ff   <= '0;
      end else begin
         state_ff    <= state_in;
         esc_ff      <= esc_in;
         cur_slot_ff <= cur_slot_in;
         cursor_ff   <= cursor_in;
      end
   end

   // Per-slot line lengths.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < HISTORY_DEPTH; s++) begin
            slot_len_ff[s] <= (s == 0) ? RESET_LEN : '0;
         end
      end else if (len_wr_en) begin
         slot_len_ff[cur_slot_ff] <= len_wr_data;
      end
   end

   // Working registers of the sequencer.
   always_ff @(posedge clock) begin
      seq_slot_ff  <= seq_slot_in;
      idx_ff       <= idx_in;
      cnt_ff       <= cnt_in;
      sub_ff       <= sub_in;
      len_ff       <= len_in;
      do_recall_ff <= do_recall_in;
      do_cmd_ff    <= do_cmd_in;
      do_prompt_ff <= do_prompt_in;
      rx_ff        <= rx_in;
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_dest_ff <= rsp_dest_in;
         rsp_byte_ff <= rsp_byte_in;
         rsp_end_ff  <= rsp_end_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_dest     = rsp_dest_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_cmd_end  = rsp_end_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

FILE: bench/line_editor_checker.sv
// Checker for the serial line editor: it watches both channels, predicts the echo and
// command bytes of each accepted request, and compares them in order with the results.
// Depends on sle_pkg for the character codes, the help length and the escape phase type.
`timescale 1ns / 1ps

module line_editor_checker
   import sle_pkg::*;
#(
   parameter int LINE_LEN      = 16,
   parameter int HISTORY_DEPTH = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_rx_byte,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic       rsp_dest,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_cmd_end,
   input  logic       rsp_last,
   output int         error_count,
   output int         outstanding
);

   // One emitted character as the editor should present it.
   typedef struct packed {
      logic       dest;
      logic [7:0] ch;
      logic       cmd_end;
      logic       last;
   } term_char_type;

   term_char_type expected_chars[$];
   term_char_type step_chars[$];

   // Private copy of the editor state.
   logic [7:0]    line_store [HISTORY_DEPTH][LINE_LEN];
   int            line_len [HISTORY_DEPTH];
   int            shown_slot;
   int            edit_pos;
   esc_phase_type esc_state;

   // Power-up contents: slot zero holds the word help.
   task automatic clear_history();
      int s;
      int i;
      for (s = 0; s < HISTORY_DEPTH; s++) begin
         line_len[s] = 0;
         for (i = 0; i < LINE_LEN; i++) line_store[s][i] = 8'h00;
      end
      line_store[0][0] = "h";
      line_store[0][1] = "e";
      line_store[0][2] = "l";
      line_store[0][3] = "p";
      line_len[0] = HELP_LEN;
      shown_slot = 0;
      edit_pos = 0;
      esc_state = ESC_NONE;
      expected_chars.delete();
   endtask

   task automatic put_char(input logic dest, input logic [7:0] ch, input logic cmd_end);
      term_char_type item;
      item.dest = dest;
      item.ch = ch;
      item.cmd_end = cmd_end;
      item.last = 1'b0;
      step_chars.push_back(item);
   endtask

   // Each removed character is shown on the terminal as BS, space, BS.
   task automatic rub_out(input int count);
      repeat (count) begin
         put_char(1'b0, CH_BS, 1'b0);
         put_char(1'b0, CH_SPACE, 1'b0);
         put_char(1'b0, CH_BS, 1'b0);
      end
   endtask

   // Works out the characters one received byte causes and queues them.
   task automatic predict_echo(input logic [7:0] c);
      int s;
      int len;
      int i;
      term_char_type tail;
      step_chars.delete();
      if (c == CH_ESC) begin
         esc_state = ESC_SEEN;
      end else if (esc_state != ESC_NONE) begin
         if (esc_state == ESC_SEEN && c == CH_BRACKET) begin
            esc_state = ESC_BRACKET;
         end else begin
            // Arrow keys replace the shown line with the neighbouring slot.
            if (esc_state == ESC_BRACKET && (c == CH_UP || c == CH_DOWN)) begin
               rub_out(edit_pos);
               if (c == CH_UP) s = (shown_slot == 0) ? HISTORY_DEPTH - 1 : shown_slot - 1;
               else s = (shown_slot + 1 >= HISTORY_DEPTH) ? 0 : shown_slot + 1;
               shown_slot = s;
               len = (line_len[s] > LINE_LEN) ? LINE_LEN : line_len[s];
               for (i = 0; i < len; i++) put_char(1'b0, line_store[s][i], 1'b0);
               edit_pos = len;
            end
            esc_state = ESC_NONE;
         end
      end else if (c == CH_BS || c == CH_DEL) begin
         if (edit_pos > 0) begin
            edit_pos--;
            rub_out(1);
         end
      end else if (c != CH_XON && c != CH_XOFF) begin
         s = shown_slot;
         // Ordinary bytes are stored and echoed while the line has room.
         if (c != CH_CR && c != CH_LF && edit_pos < LINE_LEN) begin
            line_store[s][edit_pos] = c;
            if (line_len[s] < edit_pos + 1) line_len[s] = edit_pos + 1;
            put_char(1'b0, c, 1'b0);
            edit_pos++;
         end
         // A full line or a terminator completes the line.
         if (edit_pos >= LINE_LEN || c == CH_CR || c == CH_LF) begin
            line_len[s] = edit_pos;
            if (edit_pos > 0) begin
               for (i = 0; i < edit_pos; i++)
                  put_char(1'b1, line_store[s][i], (i + 1 == edit_pos));
               shown_slot = (s + 1 >= HISTORY_DEPTH) ? 0 : s + 1;
            end
            put_char(1'b0, CH_LF, 1'b0);
            put_char(1'b0, CH_EQUALS, 1'b0);
            put_char(1'b0, CH_GT, 1'b0);
            edit_pos = 0;
         end
      end
      if (step_chars.size() > 0) begin
         tail = step_chars.pop_back();
         tail.last = 1'b1;
         step_chars.push_back(tail);
      end
      while (step_chars.size() > 0) expected_chars.push_back(step_chars.pop_front());
   endtask

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // Prediction happens before comparison within one edge.
   always @(posedge clock) begin
      term_char_type want;
      if (reset) begin
         clear_history();
         error_count = 0;
      end else begin
         if (req_valid && req_ready) predict_echo(req_rx_byte);
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               $display("%0t: unexpected result, expected none, got dest %0h byte %0h",
                        $time, rsp_dest, rsp_out_byte);
               error_count++;
            end else begin
               want = expected_chars.pop_front();
               compare_field("rsp_dest", want.dest, rsp_dest);
               compare_field("rsp_out_byte", want.ch, rsp_out_byte);
               compare_field("rsp_cmd_end", want.cmd_end, rsp_cmd_end);
               compare_field("rsp_last", want.last, rsp_last);
            end
         end
      end
      outstanding = expected_chars.size();
   end

endmodule

FILE: bench/testbench.sv
// Top of the serial line editor bench: clock, reset, request stimulus and receiver
// stalls. Depends on sle_pkg, the editor top level and line_editor_checker.
`timescale 1ns / 1ps

module testbench;
   import sle_pkg::*;

   localparam int LINE_LEN      = 16;
   localparam int HISTORY_DEPTH = 8;
   localparam int ITEM_TARGET   = 230;
   localparam int HOLD_CYCLES   = 150;
   localparam int STALL_LIMIT   = 1500;
   localparam int SETTLE_CYCLES = 80;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_dest;
   logic [7:0] rsp_out_byte;
   logic       rsp_cmd_end;
   logic       rsp_last;
   int         error_count;
   int         outstanding;

   // Stimulus controls; hold_rx and rx_idle are shared with the receiver process.
   logic tx_idle;
   logic rx_idle;
   logic hold_rx;
   int   sent_count;
   int   stall_cycles;

   serial_line_editor_with_history_top #(
      .LINE_LEN     (LINE_LEN),
      .HISTORY_DEPTH(HISTORY_DEPTH)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_dest    (rsp_dest),
      .rsp_out_byte(rsp_out_byte),
      .rsp_cmd_end (rsp_cmd_end),
      .rsp_last    (rsp_last)
   );

   line_editor_checker #(
      .LINE_LEN     (LINE_LEN),
      .HISTORY_DEPTH(HISTORY_DEPTH)
   ) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_dest    (rsp_dest),
      .rsp_out_byte(rsp_out_byte),
      .rsp_cmd_end (rsp_cmd_end),
      .rsp_last    (rsp_last),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog: too many cycles with no request or result accepted ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("[serial_line_editor_with_history_top] ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Receiver: random bursts of back-pressure, plus one long hold on request.
   initial begin
      int   gap;
      logic hold_done;
      rsp_ready = 1'b0;
      hold_done = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_rx && !hold_done) begin
            rsp_ready <= 1'b0;
            hold_done = 1'b1;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else if (rx_idle && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 13);
            rsp_ready <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Sends one byte, sometimes after a gap, and waits until it is accepted.
   task automatic type_byte(input logic [7:0] b);
      int gap;
      if (tx_idle && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 13);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (b != CH_XON && b != CH_XOFF) sent_count++;
   endtask

   // Mostly printable characters, now and then any byte at all.
   function automatic logic [7:0] any_char();
      if ($urandom_range(0, 9) != 0) return 8'($urandom_range(8'h20, 8'h7E));
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] line_end();
      return $urandom_range(0, 1) ? CH_CR : CH_LF;
   endfunction

   // A line of the given length; a full line completes without a terminator.
   task automatic type_line(input int len);
      repeat (len) type_byte(any_char());
      if (len < LINE_LEN) type_byte(line_end());
   endtask

   // Walks through the history, edits a little and completes the line.
   task automatic recall_walk();
      repeat ($urandom_range(1, 4)) begin
         type_byte(CH_ESC);
         type_byte(CH_BRACKET);
         type_byte($urandom_range(0, 1) ? CH_UP : CH_DOWN);
      end
      repeat ($urandom_range(0, 3)) begin
         if ($urandom_range(0, 2) == 0) type_byte(CH_BS);
         else type_byte(any_char());
      end
      type_byte(line_end());
   endtask

   // Escape sequences cut short or ending in an unknown final byte.
   task automatic broken_escape();
      type_byte(CH_ESC);
      case ($urandom_range(0, 2))
         0: type_byte(8'($urandom_range(0, 255)));
         1: begin
            type_byte(CH_BRACKET);
            type_byte(8'($urandom_range(0, 255)));
         end
         default: begin
            type_byte(CH_BRACKET);
            type_byte(CH_ESC);
            type_byte(8'($urandom_range(0, 255)));
         end
      endcase
   endtask

   // Up to five characters followed by one to eight rubouts, which may outnumber them.
   task automatic rubout_run();
      repeat ($urandom_range(0, 5)) type_byte(any_char());
      repeat ($urandom_range(1, 8)) type_byte($urandom_range(0, 1) ? CH_BS : CH_DEL);
      type_byte(line_end());
   endtask

   task automatic random_section(input int target);
      int pick;
      while (sent_count < target) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0, 1, 2, 3, 4: begin
               pick = $urandom_range(0, 9);
               if (pick < 6) type_line($urandom_range(0, 8));
               else if (pick < 8) type_line($urandom_range(9, LINE_LEN - 1));
               else type_line(LINE_LEN);
            end
            5, 6: recall_walk();
            7: repeat ($urandom_range(1, 6)) type_byte(8'($urandom_range(0, 255)));
            8: broken_escape();
            default: rubout_run();
         endcase
      end
   endtask

   // Stops offering requests until every predicted result has arrived.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_rx_byte = 8'h00;
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      hold_rx = 1'b0;
      sent_count = 0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // Directed opening: recall from an empty slot and of the help line, which is
      // then completed, rubouts on an empty line, extreme bytes, flow control, broken
      // escapes, a short line and an empty line completed.
      type_byte(CH_ESC); type_byte(CH_BRACKET); type_byte(CH_UP);
      type_byte(CH_ESC); type_byte(CH_BRACKET); type_byte(CH_DOWN);
      type_byte(CH_CR);
      type_byte(CH_BS); type_byte(CH_DEL);
      type_byte(8'h00); type_byte(8'hFF); type_byte(CH_XON); type_byte(CH_XOFF);
      type_byte(CH_DEL);
      type_byte(CH_ESC); type_byte(CH_ESC); type_byte(CH_BRACKET); type_byte(8'h43);
      type_byte(CH_ESC); type_byte(8'h78);
      type_byte(CH_LF); type_byte(CH_LF);

      // Long receiver hold while requests keep coming, so the input stalls.
      hold_rx = 1'b1;
      type_line(12);

      tx_idle = 1'b1;
      rx_idle = 1'b1;
      random_section(100);
      drain_results();

      // A stretch with no idling on either side.
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      random_section(140);

      tx_idle = 1'b1;
      rx_idle = 1'b1;
      random_section(190);

      tx_idle = 1'b0;
      rx_idle = 1'b0;
      random_section(ITEM_TARGET);

      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (error_count == 0 && outstanding == 0)
         $display("[serial_line_editor_with_history_top] OK");
      else
         $display("[serial_line_editor_with_history_top] ERROR");
      $finish;
   end

endmodule
